@@ rtl/pcd_pkg.sv @@
// Types and constants shared by the play command decoder and its channels.
// No dependencies.
package pcd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned RELAY_W    = 5;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [POS_W-1:0]  CMD_LEN      = 4'd8;
  localparam logic [BYTE_W-1:0] CMD_START    = 8'd98;   // 'b'
  localparam logic [BYTE_W-1:0] DIGIT_BASE   = 8'd48;   // '0'
  localparam logic [BYTE_W-1:0] TEST_BASE    = 8'd49;   // test text runs '1'..'8'
  localparam logic [BYTE_W-1:0] RESTART_BYTE = 8'd57;   // '9'

  localparam logic [BYTE_W-1:0] MAX_VOLUME_RST = 8'd30;
  localparam logic [BYTE_W-1:0] MAX_FOLDER_RST = 8'd99;

  localparam logic [BYTE_W-1:0] TEST_FOLDER = 8'd1;
  localparam logic [BYTE_W-1:0] TEST_FILE   = 8'd1;
  localparam logic [BYTE_W-1:0] TEST_VOLUME = 8'd15;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLUME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FOLDER = 8'd1;

  typedef enum logic [1:0] {
    OUT_REJECTED = 2'd0,
    OUT_PLAY     = 2'd1,
    OUT_RESTART  = 2'd2
  } outcome_t;

  // Expected byte of the test text at command position idx (0..7).
  function automatic logic [BYTE_W-1:0] test_byte(input logic [2:0] idx);
    return TEST_BASE + {5'b0, idx};
  endfunction

  // acc * 10 + d, mod 256
  function automatic logic [BYTE_W-1:0] times_ten_plus(input logic [BYTE_W-1:0] acc,
                                                       input logic [BYTE_W-1:0] d);
    return (acc << 3) + (acc << 1) + d;
  endfunction

  // One-hot relay drive; speakers without a relay give all zeros.
  function automatic logic [RELAY_W-1:0] one_hot(input logic [BYTE_W-1:0] spk);
    logic [RELAY_W-1:0] mask;
    mask = '0;
    for (int i = 0; i < RELAY_W; i++) begin
      if (spk == BYTE_W'(i)) mask[i] = 1'b1;
    end
    return mask;
  endfunction

endpackage

@@ rtl/pcd_rx_if.sv @@
// Received byte channel of the play command decoder.
// Depends on pcd_pkg.
interface pcd_rx_if;
  logic                         valid;
  logic                         ready;
  logic [pcd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/pcd_res_if.sv @@
// Result channel of the play command decoder.
// Depends on pcd_pkg.
interface pcd_res_if;
  logic                          valid;
  logic                          ready;
  pcd_pkg::outcome_t             outcome;
  logic [pcd_pkg::RELAY_W-1:0]   relay_mask;
  logic [pcd_pkg::BYTE_W-1:0]    folder_number;
  logic [pcd_pkg::BYTE_W-1:0]    file_number;
  logic [pcd_pkg::BYTE_W-1:0]    volume_level;

  modport source (output valid, output outcome, output relay_mask, output folder_number,
                  output file_number, output volume_level, input ready);
  modport sink   (input valid, input outcome, input relay_mask, input folder_number,
                  input file_number, input volume_level, output ready);
endinterface

@@ rtl/pcd_cfg_if.sv @@
// Configuration write channel of the play command decoder.
// Depends on pcd_pkg.
interface pcd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pcd_pkg::CFG_IDX_W-1:0]  index;
  logic [pcd_pkg::BYTE_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/play_command_decoder.sv @@
// Play command decoder: parses "b" + 8 digit commands into play/reject/restart results.
// Depends on pcd_pkg, pcd_rx_if, pcd_res_if, pcd_cfg_if.
//
//  channel | dir | payload                                                  | handshake
//  rx      | in  | rx_byte                                                  | valid/ready
//  res     | out | outcome, relay_mask, folder_number, file_number, volume  | valid/ready
//  cfg     | in  | index, data (0 max_volume, 1 max_folder)                 | valid/ready
//
// One byte per cycle unless rx stalls; a command's eighth byte loads its result into the
// output register on the edge that takes it, as parse state updates. rx stalls only while
// a result sits in the output register and res is not ready. cfg is always ready.
// rst (synchronous) clears parse state, relays and res valid and loads the reset limits.
module play_command_decoder #(
  parameter int unsigned SPEAKER_COUNT = 5
) (
  input  logic         clk,
  input  logic         rst,
  pcd_rx_if.sink       rx,
  pcd_res_if.source    res,
  pcd_cfg_if.sink      cfg
);

  localparam int unsigned BW = pcd_pkg::BYTE_W;

  // configuration
  logic [BW-1:0] max_volume;
  logic [BW-1:0] max_folder;

  // parse state
  logic [pcd_pkg::POS_W-1:0]   char_position, char_position_next;
  logic [BW-1:0]               speaker_acc, speaker_acc_next;
  logic [BW-1:0]               folder_acc, folder_acc_next;
  logic [BW-1:0]               file_acc, file_acc_next;
  logic [BW-1:0]               volume_acc, volume_acc_next;
  logic                        test_match, test_match_next;
  logic                        restart_match, restart_match_next;
  logic [pcd_pkg::RELAY_W-1:0] relay_state, relay_state_next;

  // output register
  logic                        res_valid;
  logic                        emit;
  pcd_pkg::outcome_t           outcome, outcome_next;
  logic [pcd_pkg::RELAY_W-1:0] relay_mask, relay_mask_next;
  logic [BW-1:0]               folder_number, folder_number_next;
  logic [BW-1:0]               file_number, file_number_next;
  logic [BW-1:0]               volume_level, volume_level_next;

  logic          rx_take;
  logic          idle;
  logic [BW-1:0] digit;
  logic [2:0]    pos_idx;

  assign rx.ready  = !res_valid || res.ready;
  assign rx_take   = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;

  assign idle    = (char_position == '0) || (char_position > pcd_pkg::CMD_LEN);
  assign digit   = rx.rx_byte - pcd_pkg::DIGIT_BASE;
  assign pos_idx = 3'(char_position - 4'd1);

  always_comb begin
    char_position_next = char_position;
    speaker_acc_next   = speaker_acc;
    folder_acc_next    = folder_acc;
    file_acc_next      = file_acc;
    volume_acc_next    = volume_acc;
    test_match_next    = test_match;
    restart_match_next = restart_match;
    relay_state_next   = relay_state;
    emit               = 1'b0;
    outcome_next       = pcd_pkg::OUT_REJECTED;
    relay_mask_next    = relay_state;
    folder_number_next = '0;
    file_number_next   = '0;
    volume_level_next  = '0;

    if (rx_take) begin
      if (idle) begin
        char_position_next = '0;
        if (rx.rx_byte == pcd_pkg::CMD_START) begin
          char_position_next = 4'd1;
          speaker_acc_next   = '0;
          folder_acc_next    = '0;
          file_acc_next      = '0;
          volume_acc_next    = '0;
          test_match_next    = 1'b1;
          restart_match_next = 1'b1;
        end
      end else begin
        test_match_next    = test_match &&
                             (rx.rx_byte == pcd_pkg::test_byte(pos_idx));
        restart_match_next = restart_match && (rx.rx_byte == pcd_pkg::RESTART_BYTE);

        // 1: speaker, 2-3: folder, 4-6: file, 7-8: volume
        priority if (char_position == 4'd1) begin
          speaker_acc_next = digit;
        end else if (char_position <= 4'd3) begin
          folder_acc_next = pcd_pkg::times_ten_plus(folder_acc, digit);
        end else if (char_position <= 4'd6) begin
          file_acc_next = pcd_pkg::times_ten_plus(file_acc, digit);
        end else begin
          volume_acc_next = pcd_pkg::times_ten_plus(volume_acc, digit);
        end

        if (char_position < pcd_pkg::CMD_LEN) begin
          char_position_next = char_position + 4'd1;
        end else begin
          char_position_next = '0;
          emit               = 1'b1;
          priority if (test_match_next) begin
            relay_state_next   = pcd_pkg::one_hot('0);
            outcome_next       = pcd_pkg::OUT_PLAY;
            relay_mask_next    = relay_state_next;
            folder_number_next = pcd_pkg::TEST_FOLDER;
            file_number_next   = pcd_pkg::TEST_FILE;
            volume_level_next  = pcd_pkg::TEST_VOLUME;
          end else if (restart_match_next) begin
            speaker_acc_next   = '0;
            folder_acc_next    = '0;
            file_acc_next      = '0;
            volume_acc_next    = '0;
            test_match_next    = 1'b1;
            restart_match_next = 1'b1;
            relay_state_next   = '0;
            outcome_next       = pcd_pkg::OUT_RESTART;
            relay_mask_next    = '0;
          end else if ((speaker_acc_next < BW'(SPEAKER_COUNT)) &&
                       (folder_acc_next <= max_folder) &&
                       (volume_acc_next <= max_volume)) begin
            relay_state_next   = pcd_pkg::one_hot(speaker_acc_next);
            outcome_next       = pcd_pkg::OUT_PLAY;
            relay_mask_next    = relay_state_next;
            folder_number_next = folder_acc_next;
            file_number_next   = file_acc_next;
            volume_level_next  = volume_acc_next;
          end else begin
            outcome_next     = pcd_pkg::OUT_REJECTED;
            relay_mask_next  = relay_state;
            file_number_next = file_acc_next;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_volume    <= pcd_pkg::MAX_VOLUME_RST;
      max_folder    <= pcd_pkg::MAX_FOLDER_RST;
      char_position <= '0;
      speaker_acc   <= '0;
      folder_acc    <= '0;
      file_acc      <= '0;
      volume_acc    <= '0;
      test_match    <= 1'b1;
      restart_match <= 1'b1;
      relay_state   <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == pcd_pkg::CFG_MAX_VOLUME) max_volume <= cfg.data;
        if (cfg.index == pcd_pkg::CFG_MAX_FOLDER) max_folder <= cfg.data;
      end
      char_position <= char_position_next;
      speaker_acc   <= speaker_acc_next;
      folder_acc    <= folder_acc_next;
      file_acc      <= file_acc_next;
      volume_acc    <= volume_acc_next;
      test_match    <= test_match_next;
      restart_match <= restart_match_next;
      relay_state   <= relay_state_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only when a new item is produced
  always_ff @(posedge clk) begin
    if (emit) begin
      outcome       <= outcome_next;
      relay_mask    <= relay_mask_next;
      folder_number <= folder_number_next;
      file_number   <= file_number_next;
      volume_level  <= volume_level_next;
    end
  end

  assign res.valid         = res_valid;
  assign res.outcome       = outcome;
  assign res.relay_mask    = relay_mask;
  assign res.folder_number = folder_number;
  assign res.file_number   = file_number;
  assign res.volume_level  = volume_level;

endmodule

@@ test/play_command_checker.sv @@
`timescale 1ns / 100ps
// Checker for the play command decoder: watches the rx, res and cfg channels,
// predicts every result and compares it field by field.
// Depends on pcd_pkg, pcd_rx_if, pcd_res_if, pcd_cfg_if.
module play_command_checker #(
  parameter int unsigned SPEAKER_COUNT = 5
) (
  input  logic clk,
  input  logic rst,
  pcd_rx_if    rx,
  pcd_res_if   res,
  pcd_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    pcd_pkg::outcome_t                outcome;
    logic [pcd_pkg::RELAY_W-1:0]      relay_mask;
    logic [pcd_pkg::BYTE_W-1:0]       folder_number;
    logic [pcd_pkg::BYTE_W-1:0]       file_number;
    logic [pcd_pkg::BYTE_W-1:0]       volume_level;
  } play_result_t;

  // parser copy
  logic [pcd_pkg::POS_W-1:0]   cmd_pos;
  logic [pcd_pkg::BYTE_W-1:0]  spk_acc;
  logic [pcd_pkg::BYTE_W-1:0]  fld_acc;
  logic [pcd_pkg::BYTE_W-1:0]  fil_acc;
  logic [pcd_pkg::BYTE_W-1:0]  vol_acc;
  bit                          test_ok;
  bit                          restart_ok;
  logic [pcd_pkg::RELAY_W-1:0] relays;

  logic [pcd_pkg::BYTE_W-1:0]  vol_limit;
  logic [pcd_pkg::BYTE_W-1:0]  fld_limit;

  play_result_t       play_results_q[$];

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("%0t ns: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [pcd_pkg::BYTE_W-1:0] got,
                             input logic [pcd_pkg::BYTE_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  function automatic void clear_parse();
    cmd_pos    = '0;
    spk_acc    = '0;
    fld_acc    = '0;
    fil_acc    = '0;
    vol_acc    = '0;
    test_ok    = 1'b1;
    restart_ok = 1'b1;
    relays     = '0;
  endfunction

  // Speakers past the relay count drive no relay at all.
  function automatic logic [pcd_pkg::RELAY_W-1:0] speaker_relay(
      input logic [pcd_pkg::BYTE_W-1:0] spk);
    logic [pcd_pkg::RELAY_W-1:0] mask;
    mask = '0;
    if (spk < pcd_pkg::RELAY_W) mask[spk[2:0]] = 1'b1;
    return mask;
  endfunction

  // Advances the parser by one byte; returns 1 when the byte ends a command.
  function automatic bit decode_byte(input logic [pcd_pkg::BYTE_W-1:0] b,
                                     output play_result_t r);
    logic [pcd_pkg::BYTE_W-1:0] digit;
    logic [pcd_pkg::POS_W-1:0]  p;
    digit = b - pcd_pkg::DIGIT_BASE;
    r = '0;
    if (cmd_pos == 0 || cmd_pos > pcd_pkg::CMD_LEN) begin
      cmd_pos = '0;
      if (b == pcd_pkg::CMD_START) begin
        cmd_pos    = 4'd1;
        spk_acc    = '0;
        fld_acc    = '0;
        fil_acc    = '0;
        vol_acc    = '0;
        test_ok    = 1'b1;
        restart_ok = 1'b1;
      end
      return 1'b0;
    end

    p = cmd_pos;
    if (b != pcd_pkg::TEST_BASE + pcd_pkg::BYTE_W'(p) - 8'd1) test_ok = 1'b0;
    if (b != pcd_pkg::RESTART_BYTE) restart_ok = 1'b0;

    if (p == 4'd1) spk_acc = digit;
    else if (p <= 4'd3) fld_acc = fld_acc * 8'd10 + digit;
    else if (p <= 4'd6) fil_acc = fil_acc * 8'd10 + digit;
    else vol_acc = vol_acc * 8'd10 + digit;

    if (p < pcd_pkg::CMD_LEN) begin
      cmd_pos = p + 4'd1;
      return 1'b0;
    end
    cmd_pos = '0;

    if (test_ok) begin
      // test text wins over the limit check
      relays = speaker_relay(8'd0);
      r = '{pcd_pkg::OUT_PLAY, relays, pcd_pkg::TEST_FOLDER, pcd_pkg::TEST_FILE,
            pcd_pkg::TEST_VOLUME};
    end else if (restart_ok) begin
      clear_parse();
      r = '{pcd_pkg::OUT_RESTART, '0, '0, '0, '0};
    end else if (spk_acc < SPEAKER_COUNT && fld_acc <= fld_limit &&
                 vol_acc <= vol_limit) begin
      relays = speaker_relay(spk_acc);
      r = '{pcd_pkg::OUT_PLAY, relays, fld_acc, fil_acc, vol_acc};
    end else begin
      // rejected: relays hold
      r = '{pcd_pkg::OUT_REJECTED, relays, '0, fil_acc, '0};
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    play_result_t want;
    play_result_t got;
    if (rst) begin
      clear_parse();
      vol_limit = pcd_pkg::MAX_VOLUME_RST;
      fld_limit = pcd_pkg::MAX_FOLDER_RST;
      play_results_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          pcd_pkg::CFG_MAX_VOLUME: vol_limit = cfg.data;
          pcd_pkg::CFG_MAX_FOLDER: fld_limit = cfg.data;
          default: ;
        endcase
      end
      if (rx.valid && rx.ready && decode_byte(rx.rx_byte, want))
        play_results_q.push_back(want);
      if (res.valid && res.ready) begin
        got = '{res.outcome, res.relay_mask, res.folder_number, res.file_number,
                res.volume_level};
        if (play_results_q.size() == 0) begin
          report_mismatch($sformatf("result with none expected: outcome %0d relays %b",
                                    got.outcome, got.relay_mask));
        end else begin
          want = play_results_q.pop_front();
          check_field("outcome", 8'(got.outcome), 8'(want.outcome));
          check_field("relay_mask", 8'(got.relay_mask), 8'(want.relay_mask));
          check_field("folder_number", got.folder_number, want.folder_number);
          check_field("file_number", got.file_number, want.file_number);
          check_field("volume_level", got.volume_level, want.volume_level);
        end
      end
    end
    pending <= play_results_q.size();
  end

endmodule

@@ test/tb_play_command_decoder.sv @@
`timescale 1ns / 100ps
// Testbench top for the play command decoder: clock, reset, byte and register
// stimulus, result-side backpressure and the verdict.
// Depends on pcd_pkg, the channel interfaces, play_command_decoder, play_command_checker.
module tb_play_command_decoder;

  localparam int unsigned SPEAKER_COUNT = 5;
  localparam int STALL_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;

  typedef logic [pcd_pkg::BYTE_W-1:0] cmd_text_t [8];

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   steady = 1'b0;    // no idling on either side
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  logic [pcd_pkg::BYTE_W-1:0] vol_cap = pcd_pkg::MAX_VOLUME_RST;
  logic [pcd_pkg::BYTE_W-1:0] fld_cap = pcd_pkg::MAX_FOLDER_RST;

  pcd_rx_if  rx ();
  pcd_res_if res ();
  pcd_cfg_if cfg ();

  always #6 clk = ~clk;

  play_command_decoder #(.SPEAKER_COUNT(SPEAKER_COUNT)) i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .res (res),
    .cfg (cfg)
  );

  play_command_checker #(.SPEAKER_COUNT(SPEAKER_COUNT)) i_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .res        (res),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    res.ready <= steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic cmd_text_t digits_of(input int spk, input int fld, input int fil,
                                          input int vol);
    cmd_text_t t;
    t[0] = pcd_pkg::DIGIT_BASE + 8'(spk % 10);
    t[1] = pcd_pkg::DIGIT_BASE + 8'(fld / 10 % 10);
    t[2] = pcd_pkg::DIGIT_BASE + 8'(fld % 10);
    t[3] = pcd_pkg::DIGIT_BASE + 8'(fil / 100 % 10);
    t[4] = pcd_pkg::DIGIT_BASE + 8'(fil / 10 % 10);
    t[5] = pcd_pkg::DIGIT_BASE + 8'(fil % 10);
    t[6] = pcd_pkg::DIGIT_BASE + 8'(vol / 10 % 10);
    t[7] = pcd_pkg::DIGIT_BASE + 8'(vol % 10);
    return t;
  endfunction

  function automatic cmd_text_t test_text();
    cmd_text_t t;
    foreach (t[i]) t[i] = pcd_pkg::TEST_BASE + 8'(i);
    return t;
  endfunction

  // Right at the limit, just past it, or anywhere in two digits.
  function automatic int near_limit(input logic [pcd_pkg::BYTE_W-1:0] cap);
    case ($urandom_range(3))
      0: return int'(cap);
      1: return int'(cap) + 1;
      default: return $urandom_range(99);
    endcase
  endfunction

  task automatic send_byte(input logic [pcd_pkg::BYTE_W-1:0] b);
    if (!steady && $urandom_range(99) < 4) begin
      rx.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
  endtask

  task automatic send_command(input cmd_text_t text);
    send_byte(pcd_pkg::CMD_START);
    foreach (text[i]) send_byte(text[i]);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pcd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pcd_pkg::BYTE_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic set_limits(input logic [pcd_pkg::BYTE_W-1:0] vol,
                            input logic [pcd_pkg::BYTE_W-1:0] fld);
    write_reg(pcd_pkg::CFG_MAX_VOLUME, vol);
    write_reg(pcd_pkg::CFG_MAX_FOLDER, fld);
    // unmapped index must be ignored
    write_reg(pcd_pkg::CFG_MAX_FOLDER + 8'd1 + 8'($urandom_range(253)),
              8'($urandom_range(255)));
    cfg.valid <= 1'b0;
    vol_cap = vol;
    fld_cap = fld;
  endtask

  task automatic run_commands(input int n);
    cmd_text_t text;
    int        kind;
    repeat (n) begin
      kind = $urandom_range(99);
      if (kind < 4) begin
        text = test_text();
      end else if (kind < 7) begin
        text = '{default: pcd_pkg::RESTART_BYTE};
      end else if (kind < 17) begin
        foreach (text[i]) text[i] = 8'($urandom_range(255));
      end else begin
        text = digits_of($urandom_range(9), near_limit(fld_cap), $urandom_range(999),
                         near_limit(vol_cap));
        if ($urandom_range(9) == 0) text[3'($urandom_range(7))] = 8'($urandom_range(255));
      end
      send_command(text);
      if ($urandom_range(99) < 25)
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    cfg.valid  = 1'b0;
    cfg.index  = '0;
    cfg.data   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // idle noise, test text, top speaker at both limits, restart clears relays
    send_byte(8'h00);
    send_byte(8'hFF);
    send_command(test_text());
    send_command(digits_of(4, 99, 999, 30));
    send_command('{default: pcd_pkg::RESTART_BYTE});
    run_commands(20);

    drain();
    set_limits(8'd0, 8'd0);
    send_command(test_text());
    send_command(digits_of(0, 0, 0, 0));
    run_commands(10);

    drain();
    set_limits(8'd255, 8'd255);
    run_commands(15);

    drain();
    set_limits(8'($urandom_range(99)), 8'($urandom_range(99)));
    run_commands(15);

    drain();
    steady <= 1'b1;
    set_limits(pcd_pkg::MAX_VOLUME_RST, pcd_pkg::MAX_FOLDER_RST);
    run_commands(20);

    drain();
    steady <= 1'b0;
    set_limits(8'($urandom_range(255)), 8'($urandom_range(99)));
    run_commands(15);

    drain();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
